// ===== hw/rtl/i2cseq_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Types and constants shared by the I2C register master sequencer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cseq_pkg;

   localparam int unsigned KIND_W    = 3;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned ADDR_W    = 7;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned MS_W      = 16;

   localparam logic [MS_W-1:0] TIMEOUT_RESET = 16'd2500;
   localparam logic [MS_W-1:0] MS_MAX        = 16'hFFFF;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE    = 3'd0,
      KIND_READ     = 3'd1,
      KIND_TX_READY = 3'd2,
      KIND_RX_BYTE  = 3'd3,
      KIND_NACK     = 3'd4,
      KIND_TICK     = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NONE     = 3'd0,
      STATUS_DONE     = 3'd1,
      STATUS_NACK     = 3'd2,
      STATUS_TIMEOUT  = 3'd3,
      STATUS_REFUSED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_WAITING = 2'd0,
      PH_READING = 2'd1,
      PH_WRITING = 2'd2
   } phase_type;

endpackage

`default_nettype wire

// ===== hw/rtl/i2cseq_if.sv =====
// ----------------------------------------------------------------------------
// i2cseq_if
// Valid/ready channels for requests, responses and the timeout register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface i2cseq_req_if;
   logic                                valid;
   logic                                ready;
   logic [i2cseq_pkg::KIND_W-1:0]       kind;
   logic [i2cseq_pkg::ADDR_W-1:0]       slave_address;
   logic [i2cseq_pkg::BYTE_W-1:0]       register_address;
   logic [i2cseq_pkg::BYTE_W-1:0]       length;
   logic [i2cseq_pkg::BYTE_W-1:0]       data_byte;

   modport source (output valid, kind, slave_address, register_address, length,
                   data_byte, input ready);
   modport sink   (input valid, kind, slave_address, register_address, length,
                   data_byte, output ready);
endinterface

interface i2cseq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [i2cseq_pkg::STATUS_W-1:0]     status;
   logic                                issue_start;
   logic                                as_receiver;
   logic                                issue_stop;
   logic [i2cseq_pkg::ADDR_W-1:0]       target_address;
   logic                                tx_valid;
   logic [i2cseq_pkg::BYTE_W-1:0]       tx_byte;
   logic                                rx_valid;
   logic [i2cseq_pkg::BYTE_W-1:0]       rx_byte;
   logic [i2cseq_pkg::BYTE_W-1:0]       buffer_index;
   logic                                bus_recovery;

   modport source (output valid, status, issue_start, as_receiver, issue_stop,
                   target_address, tx_valid, tx_byte, rx_valid, rx_byte,
                   buffer_index, bus_recovery, input ready);
   modport sink   (input valid, status, issue_start, as_receiver, issue_stop,
                   target_address, tx_valid, tx_byte, rx_valid, rx_byte,
                   buffer_index, bus_recovery, output ready);
endinterface

interface i2cseq_csr_if;
   logic                                valid;
   logic                                ready;
   logic [i2cseq_pkg::MS_W-1:0]         timeout_ms;

   modport source (output valid, timeout_ms, input ready);
   modport sink   (input valid, timeout_ms, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/i2c_register_master_sequencer.sv =====
// Response: registered; it appears in the cycle after its request transaction.
// Throughput: one request transaction per cycle; the response register is
// refilled in the same cycle it drains, so req_bus stalls only while a
// response is held by rsp_bus.ready low.
// Reset: synchronous, active high; the sequencer returns to waiting, the
// timeout register to 2500 ms, and no response is pending.
// ----------------------------------------------------------------------------
// i2c_register_master_sequencer
// Sequences register-addressed I2C writes and reads over a byte-level bus
// engine, one event in and one command/status response out per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_master_sequencer (
   input  wire               clock,
   input  wire               reset,
   i2cseq_req_if.sink        req_bus,
   i2cseq_rsp_if.source      rsp_bus,
   i2cseq_csr_if.sink        csr_bus
);

   localparam int unsigned AW = i2cseq_pkg::ADDR_W;
   localparam int unsigned BW = i2cseq_pkg::BYTE_W;
   localparam int unsigned MW = i2cseq_pkg::MS_W;

   // state
   i2cseq_pkg::phase_type     phase_ff, phase_in;
   logic                      register_sent_ff, register_sent_in;
   logic [BW-1:0]             bytes_left_ff, bytes_left_in;
   logic [BW-1:0]             first_register_ff, first_register_in;
   logic [AW-1:0]             target_ff, target_in;
   logic [BW-1:0]             next_index_ff, next_index_in;
   logic [MW-1:0]             elapsed_ff, elapsed_in;
   logic [MW-1:0]             timeout_ff;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   i2cseq_pkg::status_type    status_ff, status_in;
   logic                      start_ff, start_in;
   logic                      as_rx_ff, as_rx_in;
   logic                      stop_ff, stop_in;
   logic [AW-1:0]             taddr_ff, taddr_in;
   logic                      txv_ff, txv_in;
   logic [BW-1:0]             txb_ff, txb_in;
   logic                      rxv_ff, rxv_in;
   logic [BW-1:0]             rxb_ff, rxb_in;
   logic [BW-1:0]             index_ff, index_in;
   logic                      recover_ff, recover_in;

   logic                      accept;
   logic                      busy;
   logic                      rx_take;
   logic                      timeout_hit;
   logic [MW-1:0]             elapsed_inc;
   i2cseq_pkg::kind_type      kind;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && req_bus.ready;
   assign kind          = i2cseq_pkg::kind_type'(req_bus.kind);

   assign busy        = (phase_ff != i2cseq_pkg::PH_WAITING);
   assign rx_take     = (phase_ff == i2cseq_pkg::PH_READING) && register_sent_ff
                        && (bytes_left_ff != '0);
   assign elapsed_inc = (elapsed_ff == i2cseq_pkg::MS_MAX) ? elapsed_ff
                        : elapsed_ff + MW'(1);
   assign timeout_hit = busy && (elapsed_inc >= timeout_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (kind)
            i2cseq_pkg::KIND_WRITE,
            i2cseq_pkg::KIND_READ: begin
               if (!busy && req_bus.length != '0) begin
                  phase_in = (kind == i2cseq_pkg::KIND_WRITE) ?
                             i2cseq_pkg::PH_WRITING : i2cseq_pkg::PH_READING;
               end
            end
            i2cseq_pkg::KIND_TX_READY: begin
               if (phase_ff == i2cseq_pkg::PH_WRITING && register_sent_ff
                   && bytes_left_ff == '0) begin
                  phase_in = i2cseq_pkg::PH_WAITING;
               end
            end
            i2cseq_pkg::KIND_RX_BYTE: begin
               if (rx_take && bytes_left_ff == BW'(1)) begin
                  phase_in = i2cseq_pkg::PH_WAITING;
               end
            end
            i2cseq_pkg::KIND_NACK: begin
               phase_in = i2cseq_pkg::PH_WAITING;
            end
            i2cseq_pkg::KIND_TICK: begin
               if (timeout_hit) begin
                  phase_in = i2cseq_pkg::PH_WAITING;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // transfer bookkeeping and response fields
   always_comb begin
      register_sent_in  = register_sent_ff;
      bytes_left_in     = bytes_left_ff;
      first_register_in = first_register_ff;
      target_in         = target_ff;
      next_index_in     = next_index_ff;
      elapsed_in        = elapsed_ff;

      status_in  = i2cseq_pkg::STATUS_NONE;
      start_in   = 1'b0;
      as_rx_in   = 1'b0;
      stop_in    = 1'b0;
      taddr_in   = '0;
      txv_in     = 1'b0;
      txb_in     = '0;
      rxv_in     = 1'b0;
      rxb_in     = '0;
      index_in   = '0;
      recover_in = 1'b0;

      unique case (kind)
         i2cseq_pkg::KIND_WRITE,
         i2cseq_pkg::KIND_READ: begin
            if (busy) begin
               status_in = i2cseq_pkg::STATUS_REFUSED;
            end else if (req_bus.length == '0) begin
               status_in = i2cseq_pkg::STATUS_DONE;
            end else begin
               target_in         = req_bus.slave_address;
               first_register_in = req_bus.register_address;
               register_sent_in  = 1'b0;
               bytes_left_in     = req_bus.length;
               next_index_in     = '0;
               elapsed_in        = '0;
               start_in          = 1'b1;
               taddr_in          = req_bus.slave_address;
            end
         end
         i2cseq_pkg::KIND_TX_READY: begin
            if (busy && !register_sent_ff) begin
               register_sent_in = 1'b1;
               txv_in           = 1'b1;
               txb_in           = first_register_ff;
            end else if (phase_ff == i2cseq_pkg::PH_WRITING) begin
               if (bytes_left_ff != '0) begin
                  txv_in        = 1'b1;
                  txb_in        = req_bus.data_byte;
                  index_in      = next_index_ff;
                  next_index_in = next_index_ff + BW'(1);
                  bytes_left_in = bytes_left_ff - BW'(1);
               end else begin
                  stop_in   = 1'b1;
                  status_in = i2cseq_pkg::STATUS_DONE;
               end
            end else if (phase_ff == i2cseq_pkg::PH_READING) begin
               // repeated start as receiver; stop queued for a single byte
               start_in = 1'b1;
               as_rx_in = 1'b1;
               taddr_in = target_ff;
               stop_in  = (bytes_left_ff == BW'(1));
            end
         end
         i2cseq_pkg::KIND_RX_BYTE: begin
            if (rx_take) begin
               bytes_left_in = bytes_left_ff - BW'(1);
               if (bytes_left_ff == BW'(1)) begin
                  status_in = i2cseq_pkg::STATUS_DONE;
               end else if (bytes_left_ff == BW'(2)) begin
                  stop_in = 1'b1;
               end
               rxv_in        = 1'b1;
               rxb_in        = req_bus.data_byte;
               index_in      = next_index_ff;
               next_index_in = next_index_ff + BW'(1);
            end
         end
         i2cseq_pkg::KIND_NACK: begin
            if (busy) begin
               stop_in   = 1'b1;
               status_in = i2cseq_pkg::STATUS_NACK;
            end
         end
         i2cseq_pkg::KIND_TICK: begin
            if (busy) begin
               elapsed_in = elapsed_inc;
               if (timeout_hit) begin
                  register_sent_in  = 1'b0;
                  bytes_left_in     = '0;
                  first_register_in = '0;
                  target_in         = '0;
                  next_index_in     = '0;
                  elapsed_in        = '0;
                  stop_in           = 1'b1;
                  recover_in        = 1'b1;
                  status_in         = i2cseq_pkg::STATUS_TIMEOUT;
               end
            end
         end
         default: begin
            status_in = i2cseq_pkg::STATUS_NONE;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= i2cseq_pkg::PH_WAITING;
         register_sent_ff  <= 1'b0;
         bytes_left_ff     <= '0;
         first_register_ff <= '0;
         target_ff         <= '0;
         next_index_ff     <= '0;
         elapsed_ff        <= '0;
         timeout_ff        <= i2cseq_pkg::TIMEOUT_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            timeout_ff <= csr_bus.timeout_ms;
         end
         if (accept) begin
            phase_ff          <= phase_in;
            register_sent_ff  <= register_sent_in;
            bytes_left_ff     <= bytes_left_in;
            first_register_ff <= first_register_in;
            target_ff         <= target_in;
            next_index_ff     <= next_index_in;
            elapsed_ff        <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         start_ff   <= start_in;
         as_rx_ff   <= as_rx_in;
         stop_ff    <= stop_in;
         taddr_ff   <= taddr_in;
         txv_ff     <= txv_in;
         txb_ff     <= txb_in;
         rxv_ff     <= rxv_in;
         rxb_ff     <= rxb_in;
         index_ff   <= index_in;
         recover_ff <= recover_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.issue_start    = start_ff;
   assign rsp_bus.as_receiver    = as_rx_ff;
   assign rsp_bus.issue_stop     = stop_ff;
   assign rsp_bus.target_address = taddr_ff;
   assign rsp_bus.tx_valid       = txv_ff;
   assign rsp_bus.tx_byte        = txb_ff;
   assign rsp_bus.rx_valid       = rxv_ff;
   assign rsp_bus.rx_byte        = rxb_ff;
   assign rsp_bus.buffer_index   = index_ff;
   assign rsp_bus.bus_recovery   = recover_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/i2cseq_checker.sv =====
// ----------------------------------------------------------------------------
// i2cseq_checker
// Port-level assertions for the I2C register master sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cseq_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_ready,
   input  wire                                rsp_valid,
   input  wire                                rsp_ready,
   input  wire [i2cseq_pkg::STATUS_W-1:0]     rsp_status,
   input  wire                                rsp_issue_start,
   input  wire                                rsp_as_receiver,
   input  wire                                rsp_issue_stop,
   input  wire [i2cseq_pkg::ADDR_W-1:0]       rsp_target_address,
   input  wire                                rsp_bus_recovery
);

   // every accepted transaction shows up as a response next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("request transaction without response");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   a_held_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
                                     && $stable(rsp_issue_stop)))
      else $error("stalled response changed");

   a_addr_only_with_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_issue_start) |->
         (rsp_target_address == '0 && !rsp_as_receiver))
      else $error("target or direction without start");

   a_recovery_timeout: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bus_recovery) |->
         (rsp_issue_stop && rsp_status == i2cseq_pkg::STATUS_TIMEOUT))
      else $error("bus recovery outside timeout");

endmodule

bind i2c_register_master_sequencer i2cseq_checker u_i2cseq_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_status         (rsp_bus.status),
   .rsp_issue_start    (rsp_bus.issue_start),
   .rsp_as_receiver    (rsp_bus.as_receiver),
   .rsp_issue_stop     (rsp_bus.issue_stop),
   .rsp_target_address (rsp_bus.target_address),
   .rsp_bus_recovery   (rsp_bus.bus_recovery)
);

`default_nettype wire
